[src/mwc_pkg.sv]
package mwc_pkg;

    localparam int WORD_W    = 32;
    localparam int HALF_W    = 16;
    localparam int DIV_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HALF_W-1:0] MUL_Z = 16'd36969;
    localparam logic [HALF_W-1:0] MUL_W = 16'd18000;

    localparam logic [WORD_W-1:0] RESET_W = 32'd1;
    localparam logic [WORD_W-1:0] RESET_Z = 32'd2;

    typedef enum logic [0:0] {
        REG_SEED_W = 1'b0,
        REG_SEED_Z = 1'b1
    } reg_index_t;

    typedef logic [WORD_W-1:0] word_t;

    // one classified draw waiting for the modulo unit
    typedef struct packed {
        word_t raw;
        word_t low;
        word_t span;
        logic  span_zero;
    } draw_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic word_t mwc_advance(input word_t half, input logic [HALF_W-1:0] mul);
        logic [WORD_W-1:0] prod;
        prod = WORD_W'(half[HALF_W-1:0]) * WORD_W'(mul);
        return prod + WORD_W'(half[WORD_W-1:HALF_W]);
    endfunction

    function automatic word_t nonzero_seed(input word_t v);
        return (v == '0) ? word_t'(1) : v;
    endfunction

endpackage

[src/mwc_front.sv]
module mwc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  push,
    input  logic signed [31:0]    range_low,
    input  logic signed [31:0]    range_high,
    input  mwc_pkg::queue_status_t q_status,
    output logic                  q_write,
    output mwc_pkg::draw_t        q_item
);
    import mwc_pkg::*;

    word_t w_half_reg, w_half_next;
    word_t z_half_reg, z_half_next;
    word_t w_adv, z_adv;
    word_t low_u, high_u, span;

    assign q_write = push && !q_status.full;

    assign z_adv  = mwc_advance(z_half_reg, MUL_Z);
    assign w_adv  = mwc_advance(w_half_reg, MUL_W);
    assign low_u  = word_t'(range_low);
    assign high_u = word_t'(range_high);
    assign span   = high_u - low_u + word_t'(1);

    always_comb
    begin
        q_item.raw       = {z_adv[HALF_W-1:0], {HALF_W{1'b0}}} + w_adv;
        q_item.low       = low_u;
        q_item.span      = span;
        q_item.span_zero = (span == '0);
    end

    always_comb
    begin
        w_half_next = w_half_reg;
        z_half_next = z_half_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SEED_W: w_half_next = nonzero_seed(cfg_data);
                REG_SEED_Z: z_half_next = nonzero_seed(cfg_data);
                default: ;
            endcase
        end
        else if (q_write)
        begin
            w_half_next = w_adv;
            z_half_next = z_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_half_reg <= RESET_W;
            z_half_reg <= RESET_Z;
        end
        else
        begin
            w_half_reg <= w_half_next;
            z_half_reg <= z_half_next;
        end
    end

endmodule

[src/mwc_queue.sv]
module mwc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  mwc_pkg::draw_t         wr_item,
    input  logic                   rd_en,
    output mwc_pkg::draw_t         rd_item,
    output mwc_pkg::queue_status_t status
);
    import mwc_pkg::*;

    draw_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_wr, do_rd;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + QCNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

[src/mwc_back.sv]
module mwc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mwc_pkg::queue_status_t q_status,
    input  mwc_pkg::draw_t         q_item,
    output logic                   q_read,
    input  logic                   pop,
    output logic                   empty,
    output logic [31:0]            raw_word,
    output logic signed [31:0]     ranged_value,
    output logic                   span_zero
);
    import mwc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    word_t              rem_reg, rem_next;
    word_t              dvd_reg, dvd_next;
    word_t              raw_reg, raw_next;
    word_t              low_reg, low_next;
    word_t              span_reg, span_next;
    logic               zero_reg, zero_next;

    logic               out_valid_reg, out_valid_next;
    word_t              out_raw_reg, out_raw_next;
    word_t              out_ranged_reg, out_ranged_next;
    logic               out_zero_reg, out_zero_next;

    logic [WORD_W:0]    trial;
    logic               slot_free;

    assign empty        = !out_valid_reg;
    assign raw_word     = out_raw_reg;
    assign ranged_value = out_ranged_reg;
    assign span_zero    = out_zero_reg;

    assign slot_free = !out_valid_reg || pop;
    assign q_read    = (state_reg == S_IDLE) && !q_status.empty;
    assign trial     = {rem_reg, dvd_reg[WORD_W-1]};

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        raw_next        = raw_reg;
        low_next        = low_reg;
        span_next       = span_reg;
        zero_next       = zero_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_raw_next    = out_raw_reg;
        out_ranged_next = out_ranged_reg;
        out_zero_next   = out_zero_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    raw_next  = q_item.raw;
                    low_next  = q_item.low;
                    span_next = q_item.span;
                    zero_next = q_item.span_zero;
                    dvd_next  = q_item.raw;
                    step_next = '0;
                    // full range: no modulo, the raw word passes through
                    rem_next   = q_item.span_zero ? q_item.raw : '0;
                    state_next = q_item.span_zero ? S_DONE : S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring step: one quotient bit per cycle
                if (trial >= {1'b0, span_reg})
                    rem_next = WORD_W'(trial - {1'b0, span_reg});
                else
                    rem_next = trial[WORD_W-1:0];
                dvd_next  = {dvd_reg[WORD_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_raw_next    = raw_reg;
                    out_ranged_next = rem_reg + low_reg;
                    out_zero_next   = zero_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        raw_reg        <= raw_next;
        low_reg        <= low_next;
        span_reg       <= span_next;
        zero_reg       <= zero_next;
        out_raw_reg    <= out_raw_next;
        out_ranged_reg <= out_ranged_next;
        out_zero_reg   <= out_zero_next;
    end

endmodule

[src/mwc_random_ranged_draw.sv]
// A request accepted into the draw queue is loaded by the back end once it is idle,
// taken through 32 modulo steps, then moved to the output register once that is free.
// The bit-serial modulo unit takes no new draw before the last is done; a full-range
// draw (span zero) skips the modulo steps in the back end.
// Reset: w half = 1, z half = 2, draw queue and output register empty.
module mwc_random_ranged_draw (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        raw_word,
    output logic signed [31:0] ranged_value,
    output logic               span_zero
);
    import mwc_pkg::*;

    queue_status_t q_status;
    draw_t         wr_item;
    draw_t         rd_item;
    logic          q_write;
    logic          q_read;

    assign full = q_status.full;

    mwc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .range_low  (range_low),
        .range_high (range_high),
        .q_status   (q_status),
        .q_write    (q_write),
        .q_item     (wr_item)
    );

    mwc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_write),
        .wr_item (wr_item),
        .rd_en   (q_read),
        .rd_item (rd_item),
        .status  (q_status)
    );

    mwc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_item       (rd_item),
        .q_read       (q_read),
        .pop          (pop),
        .empty        (empty),
        .raw_word     (raw_word),
        .ranged_value (ranged_value),
        .span_zero    (span_zero)
    );

endmodule

[tb/tb_top.sv]
module tb_top;
    import mwc_pkg::*;

    localparam word_t Z_MULT = 32'd36969;
    localparam word_t W_MULT = 32'd18000;
    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [31:0] low;
        logic signed [31:0] high;
    } range_req_t;

    typedef struct {
        word_t raw;
        word_t ranged;
        logic  zflag;
    } draw_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = REG_SEED_W;
    logic [31:0]        cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic signed [31:0] range_low = '0;
    logic signed [31:0] range_high = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [31:0]        raw_word;
    logic signed [31:0] ranged_value;
    logic               span_zero;

    range_req_t   req_q[$];
    draw_result_t draw_q[$];
    range_req_t   next_req;

    word_t w_st = 32'd1;
    word_t z_st = 32'd2;

    bit idle_on = 1'b1;
    int send_gap = 0;
    int pop_gap = 0;
    int stall_cnt = 0;
    int n_err = 0;
    int n_in = 0;
    int n_out = 0;
    int n_full = 0;
    int n_seed = 0;

    mwc_random_ranged_draw u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .range_low    (range_low),
        .range_high   (range_high),
        .empty        (empty),
        .pop          (pop),
        .raw_word     (raw_word),
        .ranged_value (ranged_value),
        .span_zero    (span_zero)
    );

    always #1 clk = ~clk;

    function automatic word_t mwc_next(input word_t h, input word_t mul);
        return mul * {16'd0, h[15:0]} + {16'd0, h[31:16]};
    endfunction

    // advance both halves and queue the draw the block should return
    task automatic predict_draw(input word_t lo, input word_t hi);
        draw_result_t r;
        word_t span;
        z_st = mwc_next(z_st, Z_MULT);
        w_st = mwc_next(w_st, W_MULT);
        r.raw = {z_st[15:0], 16'd0} + w_st;
        span = hi - lo + 32'd1;
        if (span == '0)
        begin
            r.ranged = r.raw + lo;
            r.zflag = 1'b1;
            n_full++;
        end
        else
        begin
            r.ranged = (r.raw % span) + lo;
            r.zflag = 1'b0;
        end
        draw_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("tb: mismatch on %s, transaction %0d: got %h, want %h", what, n_out, got, want);
        n_err++;
    endtask

    task automatic check_result();
        draw_result_t e;
        if (draw_q.size() == 0)
        begin
            report_mismatch("unexpected result", raw_word, '0);
        end
        else
        begin
            e = draw_q.pop_front();
            if (raw_word !== e.raw)
                report_mismatch("raw_word", raw_word, e.raw);
            if (ranged_value !== e.ranged)
                report_mismatch("ranged_value", ranged_value, e.ranged);
            if (span_zero !== e.zflag)
                report_mismatch("span_zero", {31'd0, span_zero}, {31'd0, e.zflag});
        end
        n_out++;
    endtask

    task automatic add_req(input logic signed [31:0] lo, input logic signed [31:0] hi);
        range_req_t q;
        q.low = lo;
        q.high = hi;
        req_q.push_back(q);
    endtask

    function automatic range_req_t random_req();
        range_req_t q;
        int k;
        q.low = $urandom;
        q.high = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1: q.high = q.low + $urandom_range(0, 15);
            2: q.high = q.low - 1;
            3: q.high = q.low - $urandom_range(2, 100000);
            4:
            begin
                k = $urandom_range(0, 31);
                q.high = q.low + (32'd1 << k) - 1;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: q.low = SMIN;
                    1: q.low = SMAX;
                    2: q.low = 0;
                    default: q.low = -1;
                endcase
                if ($urandom_range(0, 1) == 1)
                    q.high = q.low + $urandom_range(0, 3) - 1;
            end
        endcase
        return q;
    endfunction

    // write both seeds back to back; the halves take the seed, with zero forced to one
    task automatic apply_seeds(input word_t sw, input word_t sz);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_SEED_W;
        cfg_data <= sw;
        @(posedge clk);
        w_st = (sw == '0) ? 32'd1 : sw;
        cfg_index <= REG_SEED_Z;
        cfg_data <= sz;
        @(posedge clk);
        z_st = (sz == '0) ? 32'd1 : sz;
        cfg_we <= 1'b0;
        n_seed++;
    endtask

    // hold until every queued request is sent and every draw has come back
    task automatic drain_phase();
        @(negedge clk);
        while (req_q.size() > 0 || push || draw_q.size() > 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            range_low <= '0;
            range_high <= '0;
            send_gap = 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_draw(range_low, range_high);
                n_in++;
            end
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    next_req = req_q.pop_front();
                    push <= 1'b1;
                    range_low <= next_req.low;
                    range_high <= next_req.high;
                    if (idle_on && $urandom_range(0, 6) == 0)
                        send_gap = $urandom_range(1, 3);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    pop_gap = $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                stall_cnt <= 0;
            end
            else if (stall_cnt >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset seeds: range extremes, full and inverted spans, wrapping sums
        add_req(0, 0);
        add_req(SMIN, SMAX);
        add_req(SMAX, SMIN);
        add_req(0, -1);
        add_req(SMAX, SMAX);
        add_req(SMIN, SMIN);
        add_req(-5, 5);
        add_req(5, -5);
        add_req(0, 1);
        add_req(1, 0);
        add_req(SMAX, SMAX - 1);
        add_req(SMIN + 1, SMIN);
        add_req(-1, -1);
        add_req(-1, 0);
        add_req(0, SMAX);
        add_req(SMIN, -1);
        add_req(SMIN, 0);
        add_req(SMAX, 0);
        add_req(0, SMIN);
        add_req(-100, 100);
        drain_phase();

        // zero seeds load one into each half
        apply_seeds('0, '0);
        add_req(SMIN, SMAX);
        add_req(0, 9);
        add_req(SMAX, SMIN);
        repeat (40) req_q.push_back(random_req());
        drain_phase();

        apply_seeds('1, '1);
        repeat (80) req_q.push_back(random_req());
        drain_phase();

        apply_seeds(32'h8000_0000, 32'h0000_ffff);
        repeat (80) req_q.push_back(random_req());
        drain_phase();

        for (int p = 0; p < 9; p++)
        begin
            apply_seeds($urandom, $urandom);
            if (p == 8)
                idle_on = 1'b0;
            repeat (100) req_q.push_back(random_req());
            drain_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (draw_q.size() != 0)
            report_mismatch("missing results", draw_q.size(), '0);

        $display("tb: %0d draws sent, %0d results checked, %0d seed settings",
                 n_in, n_out, n_seed);
        $display("tb: %0d full-range draws, rest split over small, inverted and wide spans",
                 n_full);
        if (n_err == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
